>>> rtl/core/cpoc_pkg.sv
`timescale 1ns / 1ps
package cpoc_pkg;

  localparam int COLOR_W = 32;
  localparam int GLYPH_W = 21;
  localparam int CH_W    = 8;
  localparam int NUM_W   = 24;  // numerator never exceeds 255 * denominator
  localparam int DEN_W   = 16;  // 255*sa + da*(255-sa) <= 65025
  localparam int Q_W     = 8;   // quotient is a channel value
  localparam int QB_W    = $clog2(Q_W);
  localparam int N_CH    = 3;   // blue, green, red
  localparam int N_PAIR  = 2;   // background, foreground

  localparam logic [CH_W-1:0] CHAN_MAX = 8'd255;

  // after the first multiply stage
  typedef struct packed {
    logic [2*CH_W-1:0] p_s;      // s * sa
    logic [2*CH_W-1:0] p_d;      // d * da
    logic              byp;
    logic [CH_W-1:0]   byp_val;
  } ch_pre_t;

  typedef struct packed {
    ch_pre_t [N_CH-1:0] ch;
    logic [DEN_W-1:0]   den_d;   // da * (255 - sa)
    logic [CH_W-1:0]    sa;
  } pair_pre_t;

  typedef struct packed {
    pair_pre_t [N_PAIR-1:0] pair;
    logic [GLYPH_W-1:0]     glyph;
  } pre_t;

  // divider stages
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             byp;
    logic [CH_W-1:0]  byp_val;
  } ch_div_t;

  typedef struct packed {
    ch_div_t [N_CH-1:0] ch;
    logic [DEN_W-1:0]   den;
    logic [CH_W-1:0]    alpha;
  } pair_div_t;

  typedef struct packed {
    pair_div_t [N_PAIR-1:0] pair;
    logic [GLYPH_W-1:0]     glyph;
  } div_t;

endpackage

>>> rtl/core/cell_pixel_over_composite.sv
`timescale 1ns / 1ps
// Straight-alpha "over" compositor for text cells.
// Input channel: in_valid/in_ready with the destination and source cells
// (background color, foreground color, glyph). Output channel:
// out_valid/out_ready with the composited cell. Colors are RGBA8888,
// red in bits 31:24, alpha in bits 7:0.
// One item per clock is accepted as long as the output side takes results.
// An item passes eleven register stages: one multiply stage, one stage that
// forms numerator, denominator and output alpha, eight restoring-division
// stages (one quotient bit each, six channels in parallel) and the output
// register.
// Each stage holds its own valid bit; a stage loads when it is empty or
// the stage after it moves, so bubbles are squeezed out while the receiver
// stalls and the block keeps taking items until all stages are full.
// No item is lost or repeated under backpressure.
// Reset (rst_n low, synchronous) clears all valid bits; the data registers
// are not reset.
module cell_pixel_over_composite (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [cpoc_pkg::COLOR_W-1:0] in_dest_bg,
  input  logic [cpoc_pkg::COLOR_W-1:0] in_dest_fg,
  input  logic [cpoc_pkg::GLYPH_W-1:0] in_dest_glyph,
  input  logic [cpoc_pkg::COLOR_W-1:0] in_src_bg,
  input  logic [cpoc_pkg::COLOR_W-1:0] in_src_fg,
  input  logic [cpoc_pkg::GLYPH_W-1:0] in_src_glyph,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [cpoc_pkg::COLOR_W-1:0] out_bg,
  output logic [cpoc_pkg::COLOR_W-1:0] out_fg,
  output logic [cpoc_pkg::GLYPH_W-1:0] out_glyph
);
  import cpoc_pkg::*;

  // stage 0: multiply, stage 1: dividend and divisor, stages 2..Q_W+1: divider,
  // last: output
  localparam int N_ST   = Q_W + 3;
  localparam int ST_OUT = N_ST - 1;

  logic [N_ST-1:0] vld_r;
  logic [N_ST-1:0] vld_nxt;
  logic [N_ST-1:0] adv;

  pre_t pre_r;
  pre_t pre_nxt;
  div_t div_r   [0:Q_W];
  div_t div_nxt [0:Q_W];

  logic [COLOR_W-1:0] out_bg_r;
  logic [COLOR_W-1:0] out_fg_r;
  logic [GLYPH_W-1:0] out_glyph_r;
  logic [COLOR_W-1:0] res_nxt [N_PAIR];

  // ---------------- handshake ----------------
  assign adv[ST_OUT]     = !vld_r[ST_OUT] || out_ready;
  assign vld_nxt[0]      = adv[0] ? in_valid : vld_r[0];

  genvar gk;
  generate
    for (gk = 0; gk < ST_OUT; gk++) begin : g_adv
      assign adv[gk]         = !vld_r[gk] || adv[gk+1];
      assign vld_nxt[gk+1]   = adv[gk+1] ? vld_r[gk] : vld_r[gk+1];
    end
  endgenerate

  assign in_ready  = adv[0];
  assign out_valid = vld_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------- stage 0: products and bypass select ----------------
  always_comb begin
    logic [COLOR_W-1:0] src;
    logic [COLOR_W-1:0] dst;
    logic [CH_W-1:0]    sa;
    logic [CH_W-1:0]    da;
    logic [CH_W-1:0]    s;
    logic [CH_W-1:0]    d;
    logic               take_s;
    logic               take_d;
    pre_nxt = '0;
    for (int p = 0; p < N_PAIR; p++) begin
      src    = (p == 0) ? in_src_bg  : in_src_fg;
      dst    = (p == 0) ? in_dest_bg : in_dest_fg;
      sa     = src[CH_W-1:0];
      da     = dst[CH_W-1:0];
      take_s = (sa == CHAN_MAX) || (da == '0);
      take_d = (sa == '0);
      pre_nxt.pair[p].sa    = sa;
      pre_nxt.pair[p].den_d = DEN_W'(da) * DEN_W'(CHAN_MAX - sa);
      for (int c = 0; c < N_CH; c++) begin
        s = src[CH_W*(c+1) +: CH_W];
        d = dst[CH_W*(c+1) +: CH_W];
        pre_nxt.pair[p].ch[c].p_s     = (2*CH_W)'(s) * (2*CH_W)'(sa);
        pre_nxt.pair[p].ch[c].p_d     = (2*CH_W)'(d) * (2*CH_W)'(da);
        pre_nxt.pair[p].ch[c].byp     = take_s || take_d;
        pre_nxt.pair[p].ch[c].byp_val = take_s ? s : d;
      end
    end
    pre_nxt.glyph = (in_src_fg[CH_W-1:0] != '0) ? in_src_glyph : in_dest_glyph;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pre_r <= pre_nxt;
    end
  end

  // ---------------- stage 1: numerator, denominator, alpha ----------------
  always_comb begin
    logic [CH_W-1:0]    sa;
    logic [CH_W-1:0]    inv;
    logic [DEN_W-1:0]   den;
    logic [DEN_W:0]     den_p1;
    logic [DEN_W:0]     a_sum;
    logic [NUM_W-1:0]   wd;
    div_nxt[0] = '0;
    for (int p = 0; p < N_PAIR; p++) begin
      sa  = pre_r.pair[p].sa;
      inv = CHAN_MAX - sa;
      den = {sa, 8'h00} - {8'h00, sa} + pre_r.pair[p].den_d;
      // exact floor(den / 255) for any 16-bit den
      den_p1 = {1'b0, den} + 17'd1;
      a_sum  = den_p1 + (den_p1 >> 8);
      div_nxt[0].pair[p].den   = den;
      div_nxt[0].pair[p].alpha = a_sum[DEN_W-1:8];
      for (int c = 0; c < N_CH; c++) begin
        wd = NUM_W'(pre_r.pair[p].ch[c].p_d) * NUM_W'(inv);
        div_nxt[0].pair[p].ch[c].rem = {pre_r.pair[p].ch[c].p_s, 8'h00}
                                     - {8'h00, pre_r.pair[p].ch[c].p_s} + wd;
        div_nxt[0].pair[p].ch[c].quo     = '0;
        div_nxt[0].pair[p].ch[c].byp     = pre_r.pair[p].ch[c].byp;
        div_nxt[0].pair[p].ch[c].byp_val = pre_r.pair[p].ch[c].byp_val;
      end
    end
    div_nxt[0].glyph = pre_r.glyph;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      div_r[0] <= div_nxt[0];
    end
  end

  // ---------------- restoring division, one quotient bit per stage ----------------
  function automatic ch_div_t div_bit(ch_div_t x, logic [DEN_W-1:0] den,
                                      logic [QB_W-1:0] b);
    logic [NUM_W-1:0] cmp;
    ch_div_t          y;
    cmp = NUM_W'(den) << b;
    y   = x;
    if (x.rem >= cmp) begin
      y.rem    = x.rem - cmp;
      y.quo[b] = 1'b1;
    end
    return y;
  endfunction

  generate
    for (gk = 1; gk <= Q_W; gk++) begin : g_div
      localparam logic [QB_W-1:0] BIT = QB_W'(Q_W - gk);
      always_comb begin
        div_nxt[gk] = div_r[gk-1];
        for (int p = 0; p < N_PAIR; p++) begin
          for (int c = 0; c < N_CH; c++) begin
            div_nxt[gk].pair[p].ch[c] = div_bit(div_r[gk-1].pair[p].ch[c],
                                                div_r[gk-1].pair[p].den, BIT);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (adv[gk+1]) begin
          div_r[gk] <= div_nxt[gk];
        end
      end
    end
  endgenerate

  // ---------------- output register ----------------
  always_comb begin
    for (int p = 0; p < N_PAIR; p++) begin
      res_nxt[p][CH_W-1:0] = div_r[Q_W].pair[p].alpha;
      for (int c = 0; c < N_CH; c++) begin
        res_nxt[p][CH_W*(c+1) +: CH_W] = div_r[Q_W].pair[p].ch[c].byp
                                       ? div_r[Q_W].pair[p].ch[c].byp_val
                                       : div_r[Q_W].pair[p].ch[c].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      out_bg_r    <= res_nxt[0];
      out_fg_r    <= res_nxt[1];
      out_glyph_r <= div_r[Q_W].glyph;
    end
  end

  assign out_bg    = out_bg_r;
  assign out_fg    = out_fg_r;
  assign out_glyph = out_glyph_r;

endmodule
